[hdl/stsr_pkg.sv]
// Package for the severity table: widths, entry record, request and response codes.
// No dependencies; the cell, row and core files refer to it by scoped names.
package stsr_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] origin;
    logic [7:0]  age;
    logic [2:0]  severity;
  } entry_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LIST   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RESP_LISTED   = 2'd0,
    RESP_REMOVED  = 2'd1,
    RESP_EMPTY    = 2'd2,
    RESP_REJECTED = 2'd3
  } resp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_LIST,
    ST_SHIFT,
    ST_SINGLE
  } state_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   clear;    // empty the sorter row
    logic   ins;      // insert entry into sorter row
    logic   shift;    // advance the sorter row toward cell 0
    logic   stage_ld; // not read by any cell; there is no staging row
  } cell_ctl_t;

endpackage

[hdl/stsr_if.sv]
// Valid/ready channel interfaces for the severity table core.
// No dependencies on other files.
interface stsr_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] entry_id;
  logic [15:0] entry_origin;
  logic [7:0]  entry_age;
  logic [2:0]  entry_severity;
  modport source (output valid, req_type, entry_id, entry_origin, entry_age,
                  entry_severity, input ready);
  modport sink (input valid, req_type, entry_id, entry_origin, entry_age,
                entry_severity, output ready);
endinterface

interface stsr_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  resp_kind;
  logic [15:0] out_id;
  logic [15:0] out_origin;
  logic [7:0]  out_age;
  logic [2:0]  out_severity;
  logic        last;
  modport source (output valid, resp_kind, out_id, out_origin, out_age,
                  out_severity, last, input ready);
  modport sink (input valid, resp_kind, out_id, out_origin, out_age,
                out_severity, last, output ready);
endinterface

[hdl/stsr_cell.sv]
// One cell of the sorting row: holds one sorted entry.
// Depends on stsr_pkg.
module stsr_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stsr_pkg::cell_ctl_t  ctl,
  input  stsr_pkg::entry_t     ins_entry,
  // neighbor toward lower index (sorted row: left neighbor)
  input  logic                 left_valid,
  input  logic                 left_lt,     // left entry age < insert age
  input  stsr_pkg::entry_t     left_entry,
  // neighbor toward higher index (for shift)
  input  logic                 right_valid,
  input  stsr_pkg::entry_t     right_entry,
  output logic                 valid,
  output logic                 lt,
  output stsr_pkg::entry_t     entry
);
  logic             valid_r, valid_nxt;
  stsr_pkg::entry_t entry_r, entry_nxt;

  assign lt = valid_r && (entry_r.age < ins_entry.age);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      // Insert point is the first cell not holding a smaller age.
      if (!lt && left_lt) begin
        // insert point: this left-entry copy is overridden below by the insert entry
        valid_nxt = left_valid;
        entry_nxt = left_entry;
      end
      if (!lt) begin
        if (left_lt) begin
          valid_nxt = 1'b1;
          entry_nxt = ins_entry;
        end else if (valid_r || left_valid) begin
          valid_nxt = left_valid;
          entry_nxt = left_entry;
        end
      end
    end else if (ctl.shift) begin
      valid_nxt = right_valid;
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;
endmodule

[hdl/stsr_row.sv]
// Row of sorting cells; entries ripple one step per cycle under a shared command.
// Depends on stsr_pkg and stsr_cell.
module stsr_row (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stsr_pkg::cell_ctl_t  ctl,
  input  stsr_pkg::entry_t     ins_entry,
  output stsr_pkg::entry_t     head
);
  logic             v  [stsr_pkg::Capacity];
  logic             l  [stsr_pkg::Capacity];
  stsr_pkg::entry_t e  [stsr_pkg::Capacity];

  for (genvar g = 0; g < stsr_pkg::Capacity; g++) begin : g_cell
    logic             lv, llt, rv;
    stsr_pkg::entry_t le, re;
    if (g == 0) begin : g_first
      assign lv  = 1'b0;
      assign llt = 1'b1;
      assign le  = '0;
    end else begin : g_mid
      assign lv  = v[g-1];
      assign llt = l[g-1];
      assign le  = e[g-1];
    end
    if (g == stsr_pkg::Capacity - 1) begin : g_end
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_nend
      assign rv = v[g+1];
      assign re = e[g+1];
    end
    stsr_cell u_cell (
      .clk, .rst_n, .ctl, .ins_entry,
      .left_valid(lv), .left_lt(llt), .left_entry(le),
      .right_valid(rv), .right_entry(re),
      .valid(v[g]), .lt(l[g]), .entry(e[g])
    );
  end

  assign head = e[0];
endmodule

[hdl/severity_table_sort_and_remove_core.sv]
// Severity table core: top level with the table store and request sequencer.
// Depends on stsr_pkg, stsr_if and stsr_row.
//
// Holds up to 16 entries. An insert gives no word unless the
// table is full (one reject word). A list request feeds the stored entries in
// order, one a cycle, through the registered memory read into a row of
// insertion-sort cells, then reads the sorted row out of its head one word a
// cycle while the output is free, writing it back into the table. A remove
// scans the table one entry a cycle for the first highest severity, then
// fetches the removed entry, closes the gap one entry a cycle and sends the
// removed word. Empty list or remove gives one empty word. The table is a
// 16-entry memory with one write and one read port; its single read port
// sets the one-entry-a-cycle pace of the load, scan and gap-closing walks.
module severity_table_sort_and_remove_core (
  input logic             clk,
  input logic             rst_n,
  stsr_in_if.sink         in_ch,
  stsr_out_if.source      out_ch
);
  localparam int IW = stsr_pkg::IdxW;
  localparam int CW = stsr_pkg::CntW;

  stsr_pkg::entry_t mem [stsr_pkg::Capacity];
  stsr_pkg::entry_t rd_r;
  logic [IW-1:0]    raddr;
  logic             we;
  logic [IW-1:0]    waddr;
  stsr_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  stsr_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;     // walk position
  logic             rdv_r, rdv_nxt;     // rd_r holds entry idx_r-1
  logic [IW-1:0]    best_r, best_nxt;
  logic [2:0]       top_r, top_nxt;
  stsr_pkg::entry_t vic_r, vic_nxt;
  logic             ov_r, ov_nxt;
  stsr_pkg::resp_t  okind_r, okind_nxt;
  stsr_pkg::entry_t oent_r, oent_nxt;
  logic             olast_r, olast_nxt;
  stsr_pkg::cell_ctl_t ctl;
  stsr_pkg::entry_t    head;
  stsr_pkg::entry_t    in_ent;

  assign in_ent = '{id: in_ch.entry_id, origin: in_ch.entry_origin,
                    age: in_ch.entry_age, severity: in_ch.entry_severity};

  stsr_row u_row (.clk, .rst_n, .ctl, .ins_entry(rd_r), .head);

  logic in_acc, out_free;
  assign out_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == stsr_pkg::ST_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; rdv_nxt = 1'b0;
    best_nxt = best_r; top_nxt = top_r; vic_nxt = vic_r;
    ov_nxt = ov_r && !out_ch.ready;
    okind_nxt = okind_r; oent_nxt = oent_r; olast_nxt = olast_r;
    ctl = '0; we = 1'b0; waddr = idx_r[IW-1:0]; wdata = in_ent;
    raddr = idx_r[IW-1:0];
    unique case (state_r)
      stsr_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          unique case (stsr_pkg::req_t'(in_ch.req_type))
            stsr_pkg::REQ_INSERT: begin
              if (cnt_r == CW'(stsr_pkg::Capacity)) begin
                ov_nxt = 1'b1; okind_nxt = stsr_pkg::RESP_REJECTED;
                oent_nxt = '0; olast_nxt = 1'b1;
              end else begin
                we = 1'b1; waddr = cnt_r[IW-1:0]; cnt_nxt = cnt_r + 1'b1;
              end
            end
            stsr_pkg::REQ_LIST, stsr_pkg::REQ_REMOVE: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1; okind_nxt = stsr_pkg::RESP_EMPTY;
                oent_nxt = '0; olast_nxt = 1'b1;
              end else if (in_ch.req_type == stsr_pkg::REQ_LIST) begin
                ctl.clear = 1'b1; state_nxt = stsr_pkg::ST_LOAD;
              end else begin
                top_nxt = '0; best_nxt = '0; state_nxt = stsr_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      stsr_pkg::ST_LOAD: begin
        // read idx_r; insert the entry read last cycle into the row
        ctl.ins = rdv_r;
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else if (!rdv_r) begin
          idx_nxt = '0; state_nxt = stsr_pkg::ST_LIST;
        end
      end
      stsr_pkg::ST_LIST: begin
        if (out_free) begin
          ov_nxt = 1'b1; okind_nxt = stsr_pkg::RESP_LISTED; oent_nxt = head;
          olast_nxt = (idx_r + 1'b1 == cnt_r);
          we = 1'b1; wdata = head; ctl.shift = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == cnt_r) state_nxt = stsr_pkg::ST_IDLE;
        end
      end
      stsr_pkg::ST_SCAN: begin
        if (rdv_r && rd_r.severity > top_r) begin
          top_nxt = rd_r.severity; best_nxt = IW'(idx_r - 1'b1);
        end
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else if (!rdv_r) begin
          // fetch the victim and start compaction
          raddr = best_r; idx_nxt = {1'b0, best_r}; state_nxt = stsr_pkg::ST_SINGLE;
        end
      end
      stsr_pkg::ST_SINGLE: begin
        vic_nxt = rd_r; raddr = IW'(idx_r + 1'b1); state_nxt = stsr_pkg::ST_SHIFT;
      end
      stsr_pkg::ST_SHIFT: begin
        // rd_r holds entry idx_r+1; write it to idx_r
        if (idx_r + 1'b1 < cnt_r) begin
          we = 1'b1; wdata = rd_r; idx_nxt = idx_r + 1'b1;
          raddr = IW'(idx_r + 2'd2);
        end else if (out_free) begin
          ov_nxt = 1'b1; okind_nxt = stsr_pkg::RESP_REMOVED; oent_nxt = vic_r;
          olast_nxt = 1'b1; cnt_nxt = cnt_r - 1'b1; state_nxt = stsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stsr_pkg::ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      rdv_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      rdv_r   <= rdv_nxt;
      ov_r    <= ov_nxt;
    end
    best_r  <= best_nxt;
    top_r   <= top_nxt;
    vic_r   <= vic_nxt;
    okind_r <= okind_nxt;
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.resp_kind    = okind_r;
  assign out_ch.out_id       = oent_r.id;
  assign out_ch.out_origin   = oent_r.origin;
  assign out_ch.out_age      = oent_r.age;
  assign out_ch.out_severity = oent_r.severity;
  assign out_ch.last         = olast_r;
endmodule
